// ----- hw/rtl/kvms_pkg.sv -----
// kvms_pkg: shared constants, types and request codes of the key/value map store
// used by the map store core
// no dependencies
package kvms_pkg;

    localparam int ENTRIES = 64;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    localparam int KEY_W  = 32;
    localparam int VAL_W  = 32;
    localparam int WORD_W = KEY_W + VAL_W;

    localparam int MODE_W    = 2;
    localparam int S_TDATA_W = KEY_W + 2 * VAL_W;
    localparam int M_TDATA_W = ((VAL_W + CNT_W + 7) / 8) * 8;
    localparam int M_TUSER_W = 2;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD     = 2'd0,
        MODE_SEARCH  = 2'd1,
        MODE_REMOVE  = 2'd2,
        MODE_REPLACE = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_APPLY = 3'b100
    } state_t;

endpackage

// ----- hw/rtl/key_value_map_store_core.sv -----
// key_value_map_store_core: fixed-capacity key/value map, one request at a time
// depends on kvms_pkg and kvms_ram
//
// usage:
//   s_ channel carries one request per beat: tuser holds the mode (add, search,
//   remove, replace), tdata holds key, value and old_value.
//   m_ channel returns exactly one result per request: tuser holds found and
//   full_refused, tdata holds data and the live entry count.
//   the pairs live in one ram word per slot; each request scans the slots one
//   read a cycle and stops at the first match, then writes back, where the mode needs it, in the apply state.
//   the block goes back to idle when the result is loaded and only then takes the
//   next request, so the rate is set by the ram scan and by any output stall.
//   the result sits in an output register; a new request is accepted while it
//   waits, and the write-back of that request holds until the result is taken.
//   reset clears all slot valid bits and the count at once; no clearing pass.
module key_value_map_store_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [kvms_pkg::S_TDATA_W-1:0]   s_tdata,  // key, value, old_value
    input  logic [kvms_pkg::MODE_W-1:0]      s_tuser,  // mode
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [kvms_pkg::M_TDATA_W-1:0]   m_tdata,  // data, entry_count, zero pad
    output logic [kvms_pkg::M_TUSER_W-1:0]   m_tuser   // found, full_refused
);

    import kvms_pkg::*;

    state_t state_reg, state_next;

    mode_t             mode_reg, mode_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [VAL_W-1:0]  val_reg, val_next;
    logic [VAL_W-1:0]  old_reg, old_next;

    logic [IDX_W-1:0]  addr_reg, addr_next;
    logic              issue_done_reg, issue_done_next;
    logic              pend_reg, pend_next;
    logic [IDX_W-1:0]  pend_idx_reg, pend_idx_next;

    logic              hit_reg, hit_next;
    logic [IDX_W-1:0]  hit_idx_reg, hit_idx_next;
    logic [VAL_W-1:0]  hit_data_reg, hit_data_next;
    logic              free_found_reg, free_found_next;
    logic [IDX_W-1:0]  free_idx_reg, free_idx_next;

    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    logic               out_valid_reg, out_valid_next;
    logic               out_found_reg, out_found_next;
    logic               out_refused_reg, out_refused_next;
    logic [VAL_W-1:0]   out_data_reg, out_data_next;
    logic [CNT_W-1:0]   out_count_reg, out_count_next;

    logic               rd_en;
    logic [WORD_W-1:0]  rd_data;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [WORD_W-1:0]  wr_data;

    logic [KEY_W-1:0]   rd_key;
    logic [VAL_W-1:0]   rd_val;
    logic               match;
    logic               apply_go;

    // slot word: key in the low half, value in the high half
    kvms_ram #(
        .WIDTH(WORD_W),
        .DEPTH(ENTRIES)
    ) u_slots (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_addr(addr_reg),
        .rd_data(rd_data)
    );

    assign rd_key = rd_data[KEY_W-1:0];
    assign rd_val = rd_data[WORD_W-1:KEY_W];

    // valid bits do not change during a scan, so the bit of the returned slot is current
    assign match = pend_reg && valid_reg[pend_idx_reg] && (rd_key == key_reg)
                   && ((mode_reg != MODE_REPLACE) || (rd_val == old_reg));

    assign s_tready = (state_reg == ST_IDLE);
    assign rd_en    = (state_reg == ST_SCAN) && !issue_done_reg;
    assign apply_go = (state_reg == ST_APPLY) && (!out_valid_reg || m_tready);

    always_comb begin
        state_next       = state_reg;
        mode_next        = mode_reg;
        key_next         = key_reg;
        val_next         = val_reg;
        old_next         = old_reg;
        addr_next        = addr_reg;
        issue_done_next  = issue_done_reg;
        pend_next        = pend_reg;
        pend_idx_next    = pend_idx_reg;
        hit_next         = hit_reg;
        hit_idx_next     = hit_idx_reg;
        hit_data_next    = hit_data_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        valid_next       = valid_reg;
        count_next       = count_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_found_next   = out_found_reg;
        out_refused_next = out_refused_reg;
        out_data_next    = out_data_reg;
        out_count_next   = out_count_reg;
        wr_en            = 1'b0;
        wr_addr          = hit_idx_reg;
        wr_data          = {val_reg, key_reg};

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    mode_next       = mode_t'(s_tuser);
                    key_next        = s_tdata[KEY_W-1:0];
                    val_next        = s_tdata[KEY_W+VAL_W-1:KEY_W];
                    old_next        = s_tdata[KEY_W+2*VAL_W-1:KEY_W+VAL_W];
                    addr_next       = '0;
                    issue_done_next = 1'b0;
                    pend_next       = 1'b0;
                    hit_next        = 1'b0;
                    free_found_next = 1'b0;
                    state_next      = ST_SCAN;
                end
            end
            ST_SCAN: begin
                pend_next     = rd_en;
                pend_idx_next = addr_reg;
                if (rd_en) begin
                    addr_next       = addr_reg + 1'b1;
                    issue_done_next = (addr_reg == LAST_IDX);
                    // lowest free slot, found as the reads go out
                    if (!free_found_reg && !valid_reg[addr_reg]) begin
                        free_found_next = 1'b1;
                        free_idx_next   = addr_reg;
                    end
                end
                if (match) begin
                    hit_next      = 1'b1;
                    hit_idx_next  = pend_idx_reg;
                    hit_data_next = rd_val;
                    state_next    = ST_APPLY;
                end else if (pend_reg && (pend_idx_reg == LAST_IDX)) begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY: begin
                if (apply_go) begin
                    out_found_next   = 1'b0;
                    out_refused_next = 1'b0;
                    out_data_next    = '0;
                    case (mode_reg)
                        MODE_ADD: begin
                            if (hit_reg) begin
                                wr_en          = 1'b1;
                                out_found_next = 1'b1;
                                out_data_next  = hit_data_reg;
                            end else if (free_found_reg) begin
                                wr_en                    = 1'b1;
                                wr_addr                  = free_idx_reg;
                                valid_next[free_idx_reg] = 1'b1;
                                count_next               = count_reg + 1'b1;
                            end else begin
                                out_refused_next = 1'b1;
                            end
                        end
                        MODE_SEARCH: begin
                            if (hit_reg) begin
                                out_found_next = 1'b1;
                                out_data_next  = hit_data_reg;
                            end
                        end
                        MODE_REMOVE: begin
                            if (hit_reg) begin
                                valid_next[hit_idx_reg] = 1'b0;
                                count_next              = count_reg - 1'b1;
                                out_found_next          = 1'b1;
                                out_data_next           = hit_data_reg;
                            end
                        end
                        MODE_REPLACE: begin
                            if (hit_reg) begin
                                wr_en          = 1'b1;
                                out_found_next = 1'b1;
                                out_data_next  = hit_data_reg;
                            end
                        end
                        default: begin
                            out_found_next = 1'b0;
                        end
                    endcase
                    out_count_next = count_next;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            valid_reg      <= '0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            issue_done_reg <= 1'b0;
            pend_reg       <= 1'b0;
        end else begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
            issue_done_reg <= issue_done_next;
            pend_reg       <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg        <= mode_next;
        key_reg         <= key_next;
        val_reg         <= val_next;
        old_reg         <= old_next;
        addr_reg        <= addr_next;
        pend_idx_reg    <= pend_idx_next;
        hit_reg         <= hit_next;
        hit_idx_reg     <= hit_idx_next;
        hit_data_reg    <= hit_data_next;
        free_found_reg  <= free_found_next;
        free_idx_reg    <= free_idx_next;
        out_found_reg   <= out_found_next;
        out_refused_reg <= out_refused_next;
        out_data_reg    <= out_data_next;
        out_count_reg   <= out_count_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'({out_count_reg, out_data_reg});
    assign m_tuser  = {out_refused_reg, out_found_reg};

    // the live count always equals the number of occupied slots
    a_count_tracks_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_reg) == 32'(count_reg))
        else $error("live count does not match valid bits");

    // a refused add only happens on a full store and never reports a hit
    a_refused_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_refused_reg) |->
            (!out_found_reg && (out_count_reg == CNT_W'(ENTRIES))))
        else $error("refused add on a store that is not full");

    // a miss returns zero data
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_found_reg) |-> (out_data_reg == '0))
        else $error("miss result carries nonzero data");

    // write-back never overwrites a result that is still waiting
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |=> (out_valid_reg && $stable(out_data_reg)))
        else $error("pending result lost");

endmodule

// ----- hw/rtl/kvms_ram.sv -----
// kvms_ram: generic single-write, single-read ram with a registered read port
// no dependencies
module kvms_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
